/* rtl/tt4_pkg.sv */
// shared types and constants of the rank-4 tensor transpose block
// no dependencies; imported by every other file of the block except tt4_ram
package tt4_pkg;

  localparam int MAX_ELEMS  = 4096;
  localparam int DATA_WIDTH = 64;
  localparam int VALUE_W    = 64;
  localparam int DIMS       = 4;
  localparam int DIM_IDX_W  = $clog2(DIMS);
  localparam int DIM_W      = 13;
  localparam int DIM_LIMIT  = 4096;
  localparam int PERM_W     = 2;
  localparam int COORD_W    = $clog2(DIM_LIMIT);
  localparam int ADDR_W     = $clog2(MAX_ELEMS);
  localparam int CNT_W      = $clog2(MAX_ELEMS + 1);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int SETTLE_CYCLES = 2;
  localparam int SETTLE_W   = $clog2(SETTLE_CYCLES + 1);

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_FULL = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_BAD_CFG  = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IN_DIM0    = 3'd0,
    CFG_IN_DIM1    = 3'd1,
    CFG_IN_DIM2    = 3'd2,
    CFG_IN_DIM3    = 3'd3,
    CFG_PERM_OUT0  = 3'd4,
    CFG_PERM_OUT1  = 3'd5,
    CFG_PERM_OUT2  = 3'd6,
    CFG_PERM_OUT3  = 3'd7
  } cfg_idx_e;

  // shape seen from the output side: size and input stride per output dimension
  typedef struct packed {
    logic                            settled;
    logic                            ok;
    logic [CNT_W-1:0]                total;
    logic [DIMS-1:0][DIM_W-1:0]      size;
    logic [DIMS-1:0][CNT_W-1:0]      stride;
  } shape_t;

endpackage

/* rtl/tt4_stream_if.sv */
// request and response channels of the tensor transpose block
// depends on tt4_pkg
interface tt4_req_if;
  import tt4_pkg::*;
  logic               valid;
  logic               ready;
  logic               op;
  logic [VALUE_W-1:0] data_value;

  modport source (output valid, op, data_value, input ready);
  modport sink   (input valid, op, data_value, output ready);
endinterface

interface tt4_rsp_if;
  import tt4_pkg::*;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] out_value;
  logic               out_last;
  logic [1:0]         status;

  modport source (output valid, out_value, out_last, status, input ready);
  modport sink   (input valid, out_value, out_last, status, output ready);
endinterface

/* rtl/tt4_ram.sv */
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module tt4_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* rtl/tt4_cfg.sv */
// configuration registers and shape unit: element count, strides, validity
// depends on tt4_pkg; two multiplier stages recompute the shape after a write
module tt4_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           we_i,
  input  logic [tt4_pkg::CFG_IDX_W-1:0]  index_i,
  input  logic [tt4_pkg::CFG_DATA_W-1:0] data_i,
  output tt4_pkg::shape_t                shape_o
);
  import tt4_pkg::*;

  logic [DIMS-1:0][DIM_W-1:0]  dim_q;
  logic [DIMS-1:0][PERM_W-1:0] perm_q;
  logic [SETTLE_W-1:0]         settle_q;

  logic [2*DIM_W-1:0]          p01_full, p23_full;
  logic [DIMS-1:0]             seen;
  logic                        perm_ok, dims_ok;

  logic [CNT_W-1:0]            p01_q, p23_q;
  logic                        over01_q, over23_q, perm_ok_q, dims_ok_q;

  logic [2*CNT_W-1:0]          tot_full;
  logic [CNT_W+DIM_W-1:0]      s0_full;
  logic                        ok_q;
  logic [CNT_W-1:0]            total_q;
  logic [DIMS-1:0][CNT_W-1:0]  stride_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIMS; k++) begin
        dim_q[k]  <= DIM_W'(1);
        perm_q[k] <= PERM_W'(k);
      end
      settle_q <= SETTLE_W'(SETTLE_CYCLES);
    end else begin
      if (we_i) begin
        settle_q <= SETTLE_W'(SETTLE_CYCLES);
        case (index_i)
          CFG_IN_DIM0:   dim_q[0]  <= data_i[DIM_W-1:0];
          CFG_IN_DIM1:   dim_q[1]  <= data_i[DIM_W-1:0];
          CFG_IN_DIM2:   dim_q[2]  <= data_i[DIM_W-1:0];
          CFG_IN_DIM3:   dim_q[3]  <= data_i[DIM_W-1:0];
          CFG_PERM_OUT0: perm_q[0] <= data_i[PERM_W-1:0];
          CFG_PERM_OUT1: perm_q[1] <= data_i[PERM_W-1:0];
          CFG_PERM_OUT2: perm_q[2] <= data_i[PERM_W-1:0];
          CFG_PERM_OUT3: perm_q[3] <= data_i[PERM_W-1:0];
          default: ;
        endcase
      end else if (settle_q != '0) begin
        settle_q <= settle_q - SETTLE_W'(1);
      end
    end
  end

  always_comb begin
    seen    = '0;
    dims_ok = 1'b1;
    for (int k = 0; k < DIMS; k++) begin
      seen[perm_q[k]] = 1'b1;
      if (dim_q[k] == '0 || dim_q[k] > DIM_W'(DIM_LIMIT)) begin
        dims_ok = 1'b0;
      end
    end
    perm_ok = &seen;
  end

  assign p01_full = (2*DIM_W)'(dim_q[0]) * (2*DIM_W)'(dim_q[1]);
  assign p23_full = (2*DIM_W)'(dim_q[2]) * (2*DIM_W)'(dim_q[3]);

  // first stage: pair products
  always_ff @(posedge clk_i) begin
    p01_q     <= p01_full[CNT_W-1:0];
    p23_q     <= p23_full[CNT_W-1:0];
    over01_q  <= p01_full > (2*DIM_W)'(MAX_ELEMS);
    over23_q  <= p23_full > (2*DIM_W)'(MAX_ELEMS);
    perm_ok_q <= perm_ok;
    dims_ok_q <= dims_ok;
  end

  assign tot_full = (2*CNT_W)'(p01_q) * (2*CNT_W)'(p23_q);
  assign s0_full  = (CNT_W+DIM_W)'(p23_q) * (CNT_W+DIM_W)'(dim_q[1]);

  // second stage: total and input strides
  always_ff @(posedge clk_i) begin
    ok_q        <= perm_ok_q && dims_ok_q && !over01_q && !over23_q &&
                   (tot_full <= (2*CNT_W)'(MAX_ELEMS));
    total_q     <= tot_full[CNT_W-1:0];
    stride_q[0] <= s0_full[CNT_W-1:0];
    stride_q[1] <= p23_q;
    stride_q[2] <= CNT_W'(dim_q[3]);
    stride_q[3] <= CNT_W'(1);
  end

  always_comb begin
    shape_o.settled = (settle_q == '0);
    shape_o.ok      = ok_q;
    shape_o.total   = total_q;
    for (int k = 0; k < DIMS; k++) begin
      shape_o.size[k]   = dim_q[perm_q[k]];
      shape_o.stride[k] = stride_q[perm_q[k]];
    end
  end

endmodule

/* rtl/tensor_transpose_rank4.sv */
// top level of the rank-4 tensor transpose block: load/read control, address
// sequencer and response register; depends on tt4_pkg, tt4_stream_if,
// tt4_cfg and tt4_ram
//
// The block takes one request per clock cycle and answers each with one
// response in the following cycle through an output register; a stalled response
// holds off the next request only while it waits. Loads fill the element ram
// in input order, reads walk the output order with a coordinate counter per
// output dimension and add the matching input stride, so each read costs one
// ram access. After reset and after every configuration write, requests are
// held off while the shape unit recomputes the element count and strides
// through its two multiplier stages. The element ram needs no clearing pass.
module tensor_transpose_rank4 (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tt4_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tt4_pkg::CFG_DATA_W-1:0] cfg_data_i,
  tt4_req_if.sink                        req_i,
  tt4_rsp_if.source                      rsp_o
);
  import tt4_pkg::*;

  shape_t                        shape;
  logic                          req_ready, accept, full;
  logic                          mem_we, mem_re;
  logic [DATA_WIDTH-1:0]         rdata;
  status_e                       status_n;

  logic [CNT_W-1:0]              load_cnt_q, load_cnt_d;
  logic [DIMS-1:0][COORD_W-1:0]  coord_q, coord_d, coord_adv;
  logic [DIMS-1:0][ADDR_W-1:0]   lvl_q, lvl_d, lvl_adv;
  logic [DIMS-1:0]               inc;
  logic                          adv_found;
  logic [DIM_IDX_W-1:0]          sel;
  logic [ADDR_W-1:0]             new_lvl;

  logic                          rsp_valid_q, last_q, rd_q;
  status_e                       status_q;

  tt4_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .shape_o (shape)
  );

  tt4_ram #(
    .DEPTH (MAX_ELEMS),
    .WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (load_cnt_q[ADDR_W-1:0]),
    .wdata_i (req_i.data_value[DATA_WIDTH-1:0]),
    .re_i    (mem_re),
    .raddr_i (lvl_q[DIMS-1]),
    .rdata_o (rdata)
  );

  assign req_ready   = shape.settled && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = req_ready;
  assign accept      = req_i.valid && req_ready;
  assign full        = load_cnt_q >= shape.total;
  assign mem_we      = accept && shape.ok && (req_i.op == OP_LOAD) && !full;
  assign mem_re      = accept && shape.ok && (req_i.op == OP_READ) && full;

  always_comb begin
    if (!shape.ok) begin
      status_n = ST_BAD_CFG;
    end else if (req_i.op == OP_LOAD) begin
      status_n = full ? ST_OVERFLOW : ST_OK;
    end else begin
      status_n = full ? ST_OK : ST_NOT_FULL;
    end
  end

  // output-order walk: innermost dimension that can still step
  always_comb begin
    adv_found = 1'b0;
    sel       = '0;
    for (int k = 0; k < DIMS; k++) begin
      inc[k] = (DIM_W'(coord_q[k]) + DIM_W'(1)) < shape.size[k];
      if (inc[k]) begin
        adv_found = 1'b1;
        sel       = DIM_IDX_W'(k);
      end
    end
    new_lvl = lvl_q[sel] + ADDR_W'(shape.stride[sel]);
    for (int k = 0; k < DIMS; k++) begin
      if (!adv_found) begin
        coord_adv[k] = '0;
        lvl_adv[k]   = '0;
      end else if (DIM_IDX_W'(k) == sel) begin
        coord_adv[k] = coord_q[k] + COORD_W'(1);
        lvl_adv[k]   = new_lvl;
      end else if (DIM_IDX_W'(k) > sel) begin
        coord_adv[k] = '0;
        lvl_adv[k]   = new_lvl;
      end else begin
        coord_adv[k] = coord_q[k];
        lvl_adv[k]   = lvl_q[k];
      end
    end
  end

  always_comb begin
    load_cnt_d = load_cnt_q;
    coord_d    = coord_q;
    lvl_d      = lvl_q;
    if (cfg_we_i) begin
      load_cnt_d = '0;
      coord_d    = '0;
      lvl_d      = '0;
    end else if (mem_we) begin
      load_cnt_d = load_cnt_q + CNT_W'(1);
    end else if (mem_re) begin
      coord_d = coord_adv;
      lvl_d   = lvl_adv;
      if (!adv_found) begin
        load_cnt_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q  <= '0;
      coord_q     <= '0;
      lvl_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      load_cnt_q <= load_cnt_d;
      coord_q    <= coord_d;
      lvl_q      <= lvl_d;
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_n;
      last_q   <= mem_re && !adv_found;
      rd_q     <= mem_re;
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.out_value = rd_q ? VALUE_W'(rdata) : '0;
  assign rsp_o.out_last  = last_q;
  assign rsp_o.status    = status_q;

  a_last_is_ok_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && last_q |-> status_q == ST_OK && rd_q)
    else $error("last flag on a response that is not an ok read");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |-> CNT_W'(lvl_q[DIMS-1]) < shape.total)
    else $error("read address beyond the loaded tensor");

  a_rearm_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re && !adv_found |=> load_cnt_q == '0 && lvl_q == '0 && coord_q == '0)
    else $error("block did not rearm after the final read");

  a_hold_after_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !req_i.ready)
    else $error("request taken before the shape settled");

endmodule

/* dv/tb_tensor_transpose_rank4.sv */
// testbench of tensor_transpose_rank4: directed and random load/read traffic with a
// scoreboard that predicts every response; depends on tt4_pkg, tt4_stream_if and the rtl
module tb_tensor_transpose_rank4;
  import tt4_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_LEN    = 400;

  typedef int unsigned dim4_t [DIMS];

  class transpose_checker;
    typedef struct {
      logic [VALUE_W-1:0] value;
      logic               last;
      status_e            status;
    } result_t;

    logic [DIM_W-1:0]   dim_size [DIMS];
    logic [PERM_W-1:0]  perm_src [DIMS];
    logic [VALUE_W-1:0] elem_store [MAX_ELEMS];
    int unsigned        loaded;
    int unsigned        reads_done;
    int unsigned        out_pos [DIMS];
    result_t            pending_results [$];
    int                 mismatch_count;

    function new();
      for (int k = 0; k < DIMS; k++) begin
        dim_size[k] = 1;
        perm_src[k] = PERM_W'(k);
      end
      mismatch_count = 0;
      rearm();
    endfunction

    function void rearm();
      loaded = 0;
      reads_done = 0;
      foreach (out_pos[k]) out_pos[k] = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
      if (idx <= CFG_IN_DIM3) begin
        dim_size[int'(idx) - int'(CFG_IN_DIM0)] = DIM_W'(val);
      end else begin
        perm_src[int'(idx) - int'(CFG_PERM_OUT0)] = val[PERM_W-1:0];
      end
      rearm();
    endfunction

    // zero when the shape or the permutation is unusable
    function longint unsigned element_count();
      logic [DIMS-1:0] seen;
      longint unsigned prod;
      seen = '0;
      prod = 1;
      for (int k = 0; k < DIMS; k++) begin
        seen[perm_src[k]] = 1'b1;
        if (dim_size[k] == 0 || dim_size[k] > DIM_LIMIT) return 0;
        prod *= dim_size[k];
      end
      if (seen != '1 || prod > MAX_ELEMS) return 0;
      return prod;
    endfunction

    function void accept_request(op_e op, logic [VALUE_W-1:0] data);
      result_t r;
      longint unsigned total;
      longint unsigned stride [DIMS];
      longint unsigned addr;
      bit last;
      r.value = '0;
      r.last = 1'b0;
      r.status = ST_OK;
      total = element_count();
      if (total == 0) begin
        r.status = ST_BAD_CFG;
      end else if (op == OP_LOAD) begin
        if (loaded >= total) begin
          r.status = ST_OVERFLOW;
        end else begin
          elem_store[loaded] = data;
          loaded++;
        end
      end else if (loaded < total) begin
        r.status = ST_NOT_FULL;
      end else begin
        stride[DIMS-1] = 1;
        for (int k = DIMS - 2; k >= 0; k--) stride[k] = stride[k+1] * dim_size[k+1];
        addr = 0;
        for (int k = 0; k < DIMS; k++) addr += out_pos[k] * stride[perm_src[k]];
        r.value = elem_store[addr];
        // walk output order, innermost dimension first
        last = 1'b1;
        for (int k = DIMS - 1; k >= 0; k--) begin
          if (out_pos[k] + 1 < dim_size[perm_src[k]]) begin
            out_pos[k]++;
            last = 1'b0;
            break;
          end
          out_pos[k] = 0;
        end
        reads_done++;
        if (last) rearm();
        r.last = last;
      end
      pending_results.push_back(r);
    endfunction

    task report(string msg);
      $display("ERROR: %s", msg);
      mismatch_count++;
    endtask

    task check_response(logic [VALUE_W-1:0] value, logic last, logic [1:0] status);
      result_t want;
      if (pending_results.size() == 0) begin
        report("response with no request outstanding");
        return;
      end
      want = pending_results.pop_front();
      if (value !== want.value) report($sformatf("out_value %h, want %h", value, want.value));
      if (last !== want.last) report($sformatf("out_last %b, want %b", last, want.last));
      if (status !== want.status) begin
        report($sformatf("status %0d, want %s", status, want.status.name()));
      end
    endtask

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  tt4_req_if req_if ();
  tt4_rsp_if rsp_if ();

  tensor_transpose_rank4 u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  transpose_checker chk;
  int unsigned req_idle_pct = 12;
  int unsigned rsp_idle_pct = 88;
  int unsigned hold_cycles = 0;
  int unsigned phase_items = 0;
  int unsigned cycle_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // response side: random stalls plus one long hold-off on demand
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        rsp_if.ready <= 1'b0;
        hold_cycles--;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      chk.check_response(rsp_if.out_value, rsp_if.out_last, rsp_if.status);
    end
  end

  function automatic logic [VALUE_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic dim4_t shuffled_perm();
    dim4_t p;
    int unsigned j, t;
    for (int k = 0; k < DIMS; k++) p[k] = k;
    for (int k = DIMS - 1; k > 0; k--) begin
      j = $urandom_range(k);
      t = p[k];
      p[k] = p[j];
      p[j] = t;
    end
    return p;
  endfunction

  function automatic dim4_t random_dims(int unsigned cap);
    dim4_t d;
    for (int k = 0; k < DIMS; k++) begin
      d[k] = ($urandom_range(7) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4);
    end
    while (d[0] * d[1] * d[2] * d[3] > cap) d[$urandom_range(DIMS - 1)] = 1;
    return d;
  endfunction

  task automatic send_req(op_e op, logic [VALUE_W-1:0] data);
    while ($urandom_range(99) < req_idle_pct) begin
      @(negedge clk_i);
      req_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    req_if.valid <= 1'b1;
    req_if.op <= op;
    req_if.data_value <= data;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    chk.accept_request(op, data);
    phase_items++;
  endtask

  // stop requesting and wait for every response before touching registers
  task automatic settle();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    chk.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_shape(dim4_t d, dim4_t p);
    logic [CFG_DATA_W-1:0] junk;
    settle();
    for (int k = 0; k < DIMS; k++) begin
      write_reg(cfg_idx_e'(int'(CFG_IN_DIM0) + k), CFG_DATA_W'(d[k]));
    end
    for (int k = 0; k < DIMS; k++) begin
      junk = CFG_DATA_W'($urandom_range(2047)) << PERM_W;
      write_reg(cfg_idx_e'(int'(CFG_PERM_OUT0) + k), junk | CFG_DATA_W'(p[k]));
    end
  endtask

  task automatic random_ops(int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_req(op_e'($urandom_range(1)), rand_word());
  endtask

  task automatic run_tensor(dim4_t d, dim4_t p, int unsigned hold_at);
    int unsigned total, early_read, reads;
    apply_shape(d, p);
    total = d[0] * d[1] * d[2] * d[3];
    early_read = ($urandom_range(9) == 0) ? $urandom_range(total - 1) : total;
    for (int unsigned i = 0; i < total; i++) begin
      if (i == early_read) send_req(OP_READ, rand_word());
      if (hold_at != 0 && i == hold_at) hold_cycles = HOLD_LEN;
      send_req(OP_LOAD, rand_word());
    end
    if ($urandom_range(6) == 0) send_req(OP_LOAD, rand_word());
    reads = ($urandom_range(9) == 0) ? $urandom_range(total) : total;
    for (int unsigned i = 0; i < reads; i++) send_req(OP_READ, rand_word());
  endtask

  task automatic random_episode();
    int unsigned pick, a;
    dim4_t d, p;
    pick = $urandom_range(99);
    if (pick < 78) begin
      run_tensor(random_dims(256), shuffled_perm(), 0);
    end else if (pick < 90) begin
      d = random_dims(64);
      p = shuffled_perm();
      case ($urandom_range(3))
        0: begin
          a = $urandom_range(DIMS - 1);
          p[a] = p[(a + 1 + $urandom_range(DIMS - 2)) % DIMS];
        end
        1: d[$urandom_range(DIMS - 1)] = 0;
        2: d[$urandom_range(DIMS - 1)] = $urandom_range(DIM_LIMIT + 1, (1 << DIM_W) - 1);
        default: begin
          d[0] = $urandom_range(2, 64);
          d[1] = $urandom_range(DIM_LIMIT / d[0] + 1, DIM_LIMIT);
        end
      endcase
      apply_shape(d, p);
      random_ops($urandom_range(2, 6));
    end else begin
      random_ops($urandom_range(4, 12));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_IN_DIM0;
    cfg_data_i = '0;
    req_if.valid = 1'b0;
    req_if.op = OP_LOAD;
    req_if.data_value = '0;
    chk = new();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // single-element tensor after reset
    send_req(OP_READ, '0);
    send_req(OP_LOAD, '1);
    send_req(OP_LOAD, rand_word());
    send_req(OP_READ, rand_word());
    send_req(OP_LOAD, '0);
    send_req(OP_READ, '1);

    // small transpose of the two inner dimensions
    apply_shape('{1, 1, 2, 3}, '{0, 1, 3, 2});
    send_req(OP_LOAD, '1);
    send_req(OP_LOAD, '0);
    for (int i = 0; i < 4; i++) send_req(OP_LOAD, rand_word());
    for (int i = 0; i < 6; i++) send_req(OP_READ, rand_word());

    // unusable configurations
    apply_shape('{1, 1, 2, 3}, '{0, 0, 3, 2});
    send_req(OP_LOAD, rand_word());
    send_req(OP_READ, rand_word());
    settle();
    write_reg(CFG_PERM_OUT1, CFG_DATA_W'(1));
    write_reg(CFG_IN_DIM0, '0);
    send_req(OP_LOAD, rand_word());
    settle();
    write_reg(CFG_IN_DIM0, '1);
    send_req(OP_READ, rand_word());
    apply_shape('{DIM_LIMIT, 2, 1, 1}, '{0, 1, 2, 3});
    send_req(OP_LOAD, rand_word());
    settle();
    write_reg(CFG_IN_DIM1, CFG_DATA_W'(1));
    send_req(OP_LOAD, rand_word());
    send_req(OP_READ, rand_word());

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          req_idle_pct = 12;
          rsp_idle_pct = 88;
        end
        1: begin
          req_idle_pct = 88;
          rsp_idle_pct = 12;
        end
        default: begin
          req_idle_pct = 0;
          rsp_idle_pct = 0;
        end
      endcase
      phase_items = 0;
      while (phase_items < 180) random_episode();
    end

    // tensor with a long response stall during the load
    run_tensor('{1, 2, 4, 8}, shuffled_perm(), 40);

    settle();
    repeat (8) @(posedge clk_i);
    if (chk.pending() != 0) chk.report($sformatf("%0d responses never arrived", chk.pending()));
    if (chk.mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
